/* design/wta_pkg.sv */
// Shared types and constants for the windowed trapezoid average block.
// Used by wta_ctrl, wta_dp and windowed_trapezoid_average; no dependencies.
package wta_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;
	localparam int ACCW  = 80;
	localparam int MAGW  = ACCW + 1;
	localparam int DCW   = $clog2(MAGW + 1);
	localparam int RETW  = 20;
	localparam logic [RETW-1:0] RET_RESET = RETW'(3600);

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_NO_DATA  = 2'd1,
		STS_ZERO_SPAN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SRC_ZERO  = 2'd0,
		SRC_RDATA = 2'd1,
		SRC_DIV   = 2'd2
	} res_src_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADD, ST_TRIM_RD, ST_TRIM_CHK, ST_Q0, ST_T0, ST_SKIP_CHK,
		ST_SKIP_RD, ST_SPAN_CHK, ST_SPAN_RD, ST_SPAN_MUL, ST_SPAN_ACC, ST_DIV, ST_FIN
	} state_t;

	typedef struct packed {
		logic     cap;
		logic     wr;
		logic     rd_en;
		logic     rd_trim;
		logic     cnt_dec;
		logic     k_inc;
		logic     load_t0;
		logic     load_t1;
		logic     load_cur;
		logic     mul;
		logic     acc_add;
		logic     div_init;
		logic     div_step;
		logic     res_load;
		res_src_t res_src;
		status_t  res_status;
		logic     out_push;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic empty;
		logic gt1;
		logic drop;
		logic skip_lt;
		logic k_last;
		logic avg_zero;
		logic span_lt;
		logic den_zero;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

/* design/wta_ctrl.sv */
// Controller state machine for the windowed trapezoid average block.
// Depends on wta_pkg; drives wta_dp through cmd_t, reads sts_t.
module wta_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	output logic           in_ready,
	input  wta_pkg::sts_t  sts,
	output wta_pkg::cmd_t  cmd
);

	wta_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wta_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx       = state_q;
		cmd            = '0;
		cmd.res_src    = wta_pkg::SRC_ZERO;
		cmd.res_status = wta_pkg::STS_OK;
		in_ready       = 1'b0;
		unique case (state_q)
			wta_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.cap  = 1'b1;
					state_nx = sts.op ? wta_pkg::ST_Q0 : wta_pkg::ST_ADD;
				end
			end
			wta_pkg::ST_ADD: begin
				cmd.wr   = 1'b1;
				state_nx = wta_pkg::ST_TRIM_RD;
			end
			wta_pkg::ST_TRIM_RD: begin
				if (sts.gt1) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_trim = 1'b1;
					state_nx    = wta_pkg::ST_TRIM_CHK;
				end else begin
					state_nx = wta_pkg::ST_IDLE;
				end
			end
			wta_pkg::ST_TRIM_CHK: begin
				if (sts.drop) begin
					cmd.cnt_dec = 1'b1;
					state_nx    = wta_pkg::ST_TRIM_RD;
				end else begin
					state_nx = wta_pkg::ST_IDLE;
				end
			end
			wta_pkg::ST_Q0: begin
				if (sts.empty) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = wta_pkg::STS_NO_DATA;
					state_nx       = wta_pkg::ST_FIN;
				end else begin
					cmd.rd_en = 1'b1;
					state_nx  = wta_pkg::ST_T0;
				end
			end
			wta_pkg::ST_T0: begin
				cmd.load_t0 = 1'b1;
				state_nx    = wta_pkg::ST_SKIP_CHK;
			end
			wta_pkg::ST_SKIP_CHK: begin
				if (sts.skip_lt) begin
					if (sts.k_last) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = wta_pkg::STS_NO_DATA;
						state_nx       = wta_pkg::ST_FIN;
					end else begin
						cmd.k_inc = 1'b1;
						state_nx  = wta_pkg::ST_SKIP_RD;
					end
				end else if (sts.avg_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_src  = wta_pkg::SRC_RDATA;
					state_nx     = wta_pkg::ST_FIN;
				end else begin
					cmd.load_t1  = 1'b1;
					cmd.load_cur = 1'b1;
					state_nx     = wta_pkg::ST_SPAN_CHK;
				end
			end
			wta_pkg::ST_SKIP_RD: begin
				cmd.rd_en = 1'b1;
				state_nx  = wta_pkg::ST_SKIP_CHK;
			end
			wta_pkg::ST_SPAN_CHK: begin
				if (sts.span_lt) begin
					if (sts.k_last) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = wta_pkg::STS_NO_DATA;
						state_nx       = wta_pkg::ST_FIN;
					end else begin
						cmd.k_inc = 1'b1;
						state_nx  = wta_pkg::ST_SPAN_RD;
					end
				end else if (sts.den_zero) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = wta_pkg::STS_ZERO_SPAN;
					state_nx       = wta_pkg::ST_FIN;
				end else begin
					cmd.div_init = 1'b1;
					state_nx     = wta_pkg::ST_DIV;
				end
			end
			wta_pkg::ST_SPAN_RD: begin
				cmd.rd_en = 1'b1;
				state_nx  = wta_pkg::ST_SPAN_MUL;
			end
			wta_pkg::ST_SPAN_MUL: begin
				cmd.mul      = 1'b1;
				cmd.load_cur = 1'b1;
				state_nx     = wta_pkg::ST_SPAN_ACC;
			end
			wta_pkg::ST_SPAN_ACC: begin
				cmd.acc_add = 1'b1;
				state_nx    = wta_pkg::ST_SPAN_CHK;
			end
			wta_pkg::ST_DIV: begin
				if (sts.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_src  = wta_pkg::SRC_DIV;
					state_nx     = wta_pkg::ST_FIN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			wta_pkg::ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_push = 1'b1;
					state_nx     = wta_pkg::ST_IDLE;
				end
			end
			default: state_nx = wta_pkg::ST_IDLE;
		endcase
	end

endmodule

/* design/wta_dp.sv */
// Datapath: sample ring memory, walk registers, multiply-accumulate,
// restoring divider and output register. Depends on wta_pkg.
module wta_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wta_pkg::cmd_t               cmd,
	output wta_pkg::sts_t               sts,
	input  logic                        in_op,
	input  logic [31:0]                 in_value,
	input  logic [31:0]                 in_time,
	input  logic [15:0]                 in_avg,
	input  logic [15:0]                 in_skip,
	input  logic [wta_pkg::RETW-1:0]    retention,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 out_value,
	output logic [1:0]                  out_status
);

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] value;
	} entry_t;

	entry_t mem_q [wta_pkg::DEPTH];
	entry_t rd_q;

	logic [31:0] val_q, time_q, t0_q, t1_q, cur_val_q, cur_st_q;
	logic [15:0] avg_q, skip_q;
	logic [wta_pkg::AW-1:0] newest_q, rd_addr;
	logic [wta_pkg::CW-1:0] count_q, k_q, count_m1;
	logic signed [65:0] prod_s1;
	logic signed [wta_pkg::ACCW-1:0] acc_q;
	logic neg_q;
	logic [wta_pkg::MAGW-1:0] mag_q;
	logic [33:0] dvs_q;
	logic [33:0] rem_q;
	logic [wta_pkg::DCW-1:0] dcnt_q;
	logic [31:0] res_val_q, out_val_q;
	logic [1:0] res_st_q, out_st_q;
	logic out_valid_q;

	logic signed [32:0] age, skip_d, span_d, den, mul_a, mul_b;
	logic [32:0] dmag;
	logic [wta_pkg::ACCW-1:0] acc_mag;
	logic [34:0] rsh;
	logic qbit, qbig;
	logic [31:0] div_val, res_val_d;

	assign count_m1 = count_q - wta_pkg::CW'(1);
	assign rd_addr  = cmd.rd_trim ? newest_q - count_m1[wta_pkg::AW-1:0]
	                              : newest_q - k_q[wta_pkg::AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[newest_q + wta_pkg::AW'(1)] <= '{stamp: time_q, value: val_q};
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign age    = $signed({1'b0, time_q}) - $signed({1'b0, rd_q.stamp});
	assign skip_d = $signed({1'b0, t0_q}) - $signed({1'b0, rd_q.stamp});
	assign span_d = $signed({1'b0, t1_q}) - $signed({1'b0, cur_st_q});
	assign den    = span_d;
	assign dmag   = den[32] ? 33'(-den) : 33'(den);
	assign acc_mag = acc_q[wta_pkg::ACCW-1] ? wta_pkg::ACCW'(-acc_q) : wta_pkg::ACCW'(acc_q);
	assign mul_a  = $signed({cur_val_q[31], cur_val_q}) + $signed({rd_q.value[31], rd_q.value});
	assign mul_b  = $signed({1'b0, cur_st_q}) - $signed({1'b0, rd_q.stamp});

	assign rsh  = {rem_q, mag_q[wta_pkg::MAGW-1]};
	assign qbit = rsh >= {1'b0, dvs_q};
	assign qbig = |mag_q[wta_pkg::MAGW-1:31];

	always_comb begin
		if (neg_q) begin
			div_val = qbig ? 32'h8000_0000 : 32'(-mag_q[31:0]);
		end else begin
			div_val = qbig ? 32'h7FFF_FFFF : mag_q[31:0];
		end
		unique case (cmd.res_src)
			wta_pkg::SRC_RDATA: res_val_d = rd_q.value;
			wta_pkg::SRC_DIV:   res_val_d = div_val;
			default:            res_val_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q    <= '0;
			count_q     <= '0;
			k_q         <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + wta_pkg::CW'(1);
			end
			if (cmd.wr) begin
				newest_q <= newest_q + wta_pkg::AW'(1);
				if (count_q < wta_pkg::CW'(wta_pkg::DEPTH)) begin
					count_q <= count_q + wta_pkg::CW'(1);
				end
			end else if (cmd.cnt_dec) begin
				count_q <= count_m1;
			end
			if (cmd.div_init) begin
				dcnt_q <= wta_pkg::DCW'(wta_pkg::MAGW);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - wta_pkg::DCW'(1);
			end
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			val_q  <= in_value;
			time_q <= in_time;
			avg_q  <= in_avg;
			skip_q <= in_skip;
			acc_q  <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + wta_pkg::ACCW'(prod_s1);
		end
		if (cmd.load_t0) t0_q <= rd_q.stamp;
		if (cmd.load_t1) t1_q <= rd_q.stamp;
		if (cmd.load_cur) begin
			cur_val_q <= rd_q.value;
			cur_st_q  <= rd_q.stamp;
		end
		if (cmd.mul) prod_s1 <= mul_a * mul_b;
		if (cmd.div_init) begin
			neg_q <= acc_q[wta_pkg::ACCW-1] ^ den[32];
			mag_q <= {1'b0, acc_mag} + wta_pkg::MAGW'(dmag);
			dvs_q <= {dmag, 1'b0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			mag_q <= {mag_q[wta_pkg::MAGW-2:0], qbit};
			rem_q <= qbit ? 34'(rsh - {1'b0, dvs_q}) : rsh[33:0];
		end
		if (cmd.res_load) begin
			res_val_q <= res_val_d;
			res_st_q  <= cmd.res_status;
		end
		if (cmd.out_push) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
		end
	end

	always_comb begin
		sts.op       = in_op;
		sts.empty    = count_q == '0;
		sts.gt1      = count_q > wta_pkg::CW'(1);
		sts.drop     = age >= $signed({13'b0, retention});
		sts.skip_lt  = skip_d < $signed({17'b0, skip_q});
		sts.k_last   = (k_q + wta_pkg::CW'(1)) >= count_q;
		sts.avg_zero = avg_q == '0;
		sts.span_lt  = span_d < $signed({17'b0, avg_q});
		sts.den_zero = t1_q == cur_st_q;
		sts.div_done = dcnt_q == '0;
		sts.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_val_q;
	assign out_status = out_st_q;

endmodule

/* design/windowed_trapezoid_average.sv */
// Time-weighted moving average over a ring of timestamped samples.
// Slave channel s_*: tuser = op (0 add, 1 query); tdata = sample_value,
//   sample_time, average_span, skip_span from bit 0 up.
// Master channel m_*: one result per query; tdata = mean_value,
//   tuser = status (0 ok, 1 no_data, 2 zero_span). Adds give no result.
// Config: APB, retention_seconds at address 0, resets to 3600.
// One request is worked at a time; s_tready is high only while idle.
// Add: writes the sample, then drops the oldest samples past retention.
// Query: walks the skipped entries, then the averaged entries, then runs
//   the bit-serial divider; the ring memory's single read port sets the
//   walk rate.
// Reset empties the ring; memory contents need no clearing.
// A result waits in the output register while m_tready is low; the next
// request is still taken, and a following query holds until it drains.
// Depends on wta_pkg, wta_ctrl, wta_dp.
module windowed_trapezoid_average (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // sample_value, sample_time, average_span, skip_span
	input  logic [0:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // mean_value
	output logic [1:0]  m_tuser,   // status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	wta_pkg::cmd_t cmd;
	wta_pkg::sts_t sts;
	logic [wta_pkg::RETW-1:0] ret_q;
	logic in_fire;

	assign pready  = 1'b1;
	assign prdata  = paddr[2] ? 32'd0 : {12'd0, ret_q};
	assign in_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q <= wta_pkg::RET_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			ret_q <= pwdata[wta_pkg::RETW-1:0];
		end
	end

	wta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wta_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_tuser[0]),
		.in_value   (s_tdata[31:0]),
		.in_time    (s_tdata[63:32]),
		.in_avg     (s_tdata[79:64]),
		.in_skip    (s_tdata[95:80]),
		.retention  (ret_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (m_tuser)
	);

endmodule

/* dv/wta_checker.sv */
`timescale 1ns / 100ps
// Checker for windowed_trapezoid_average: watches the stream and APB ports,
// predicts every query result and compares it. Depends on wta_pkg.
module wta_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatch_count
);
	import wta_pkg::*;

	localparam logic [2:0] ADDR_RETENTION = 3'd0;
	localparam logic       OP_ADD = 1'b0;

	typedef struct packed {
		logic [31:0] mean;
		status_t     status;
	} avg_result_t;

	logic [31:0]    stamp_mem [DEPTH];
	logic [31:0]    value_mem [DEPTH];
	int             head_slot;
	int             ring_count;
	logic [RETW-1:0] retention;
	avg_result_t    expected_q [$];

	initial mismatch_count = 0;

	function automatic int slot_at(int rank);
		return (head_slot + DEPTH - (rank % DEPTH)) % DEPTH;
	endfunction

	function automatic longint stamp_at(int rank);
		return longint'(stamp_mem[slot_at(rank)]);
	endfunction

	function automatic longint value_at(int rank);
		return longint'($signed(value_mem[slot_at(rank)]));
	endfunction

	function automatic void store_sample(logic [31:0] v, logic [31:0] t);
		head_slot = (head_slot + 1) % DEPTH;
		stamp_mem[head_slot] = t;
		value_mem[head_slot] = v;
		if (ring_count < DEPTH)
			ring_count++;
		while (ring_count > 1) begin
			if (longint'(t) - stamp_at(ring_count - 1) < longint'(retention))
				break;
			ring_count--;
		end
	endfunction

	function automatic avg_result_t average_query(logic [15:0] avg_span, logic [15:0] skip_span);
		avg_result_t r;
		int k;
		longint t0, t1, den, a, dt, dmag;
		logic signed [127:0] acc, term;
		logic [127:0] mag, q;
		bit neg;
		r.mean = '0;
		r.status = STS_NO_DATA;
		k = 0;
		acc = '0;
		if (ring_count == 0)
			return r;
		t0 = stamp_at(0);
		while (t0 - stamp_at(k) < longint'(skip_span)) begin
			k++;
			if (k >= ring_count)
				return r;
		end
		if (avg_span == 0) begin
			r.mean = value_mem[slot_at(k)];
			r.status = STS_OK;
			return r;
		end
		t1 = stamp_at(k);
		while (t1 - stamp_at(k) < longint'(avg_span)) begin
			if (k + 1 >= ring_count)
				return r;
			a = value_at(k) + value_at(k + 1);
			dt = stamp_at(k) - stamp_at(k + 1);
			term = a;
			term = term * dt;
			acc = acc + term;
			k++;
		end
		den = t1 - stamp_at(k);
		if (den == 0) begin
			r.status = STS_ZERO_SPAN;
			return r;
		end
		neg = acc < 0;
		mag = neg ? -acc : acc;
		dmag = den < 0 ? -den : den;
		mag = mag + 128'(dmag);
		q = mag / (128'(dmag) * 2);
		if (den < 0)
			neg = !neg;
		r.status = STS_OK;
		if (neg)
			r.mean = (q >= 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
		else
			r.mean = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		avg_result_t exp_r;
		if (!arst_n) begin
			head_slot = 0;
			ring_count = 0;
			retention = RET_RESET;
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_RETENTION)
				retention = pwdata[RETW-1:0];
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_ADD)
					store_sample(s_tdata[31:0], s_tdata[63:32]);
				else
					expected_q.push_back(average_query(s_tdata[79:64], s_tdata[95:80]));
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result: mean_value %h status %0d", m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (m_tdata !== exp_r.mean) begin
						$error("mean_value: expected %h, actual %h", exp_r.mean, m_tdata);
						mismatch_count++;
					end
					if (m_tuser !== exp_r.status) begin
						$error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
						mismatch_count++;
					end
				end
			end
		end
	end

endmodule

/* dv/tb_windowed_trapezoid_average.sv */
`timescale 1ns / 100ps
// Top of the windowed_trapezoid_average testbench: clock, reset, stimulus,
// idling and verdict. Depends on wta_pkg, wta_checker and the block.
module tb_windowed_trapezoid_average;
	import wta_pkg::*;

	localparam int          WATCHDOG_LIMIT = 40000;
	localparam logic [2:0]  ADDR_RETENTION = 3'd0;
	localparam logic [2:0]  ADDR_UNUSED    = 3'd4;
	localparam logic        OP_ADD   = 1'b0;
	localparam logic        OP_QUERY = 1'b1;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int          mismatch_count;
	int          queries_sent = 0;
	int          results_seen = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic [31:0] clock_now = '0;

	windowed_trapezoid_average u_dut (.*);

	wta_checker u_checker (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.mismatch_count
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (m_tvalid && m_tready)
			results_seen <= results_seen + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [31:0] v, logic [31:0] t,
			logic [15:0] avg_span, logic [15:0] skip_span);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {skip_span, avg_span, t, v};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_QUERY)
			queries_sent++;
	endtask

	task automatic add_sample(logic [31:0] v, logic [31:0] t);
		send_request(OP_ADD, v, t, 16'($urandom), 16'($urandom));
	endtask

	task automatic query(logic [15:0] avg_span, logic [15:0] skip_span);
		send_request(OP_QUERY, $urandom, $urandom, avg_span, skip_span);
	endtask

	// drain all results, then let any trimming finish before going on
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (queries_sent != results_seen)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic random_phase(int n, bit pause_midway);
		logic [31:0] v;
		int r;
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2)
				wait_idle();
			r = $urandom_range(0, 99);
			if (r < 55) begin
				v = ($urandom_range(0, 9) == 0) ? {$urandom_range(0, 1) ? 32'h7FFF_FFFF
					: 32'h8000_0000} : $urandom;
				if (r < 4)
					add_sample(v, clock_now - $urandom_range(1, 100));
				else begin
					clock_now = clock_now + $urandom_range(0, 30);
					add_sample(v, clock_now);
				end
			end else if (r < 62) begin
				query(16'($urandom), 16'($urandom));
			end else begin
				query(($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 150)),
					($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 60)));
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty ring, extremes, equal stamps, skip and span limits
		query(16'd0, 16'd0);
		add_sample(32'h7FFF_FFFF, 32'd100);
		query(16'd0, 16'd0);
		query(16'd5, 16'd0);
		add_sample(32'h8000_0000, 32'd110);
		add_sample(32'h0000_0000, 32'd110);
		add_sample(32'h0000_0001, 32'd125);
		query(16'd0, 16'd0);
		query(16'd10, 16'd0);
		query(16'd0, 16'd5);
		query(16'd0, 16'd1000);
		query(16'd1000, 16'd0);
		query(16'd15, 16'd10);
		query(16'hFFFF, 16'hFFFF);
		query(16'd25, 16'd0);
		wait_idle();
		apb_write(ADDR_RETENTION, 32'd1);
		add_sample(32'h0001_0000, 32'd130);
		add_sample(32'hFFFF_0000, 32'd130);
		query(16'd0, 16'd0);
		wait_idle();
		apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
		apb_write(ADDR_RETENTION, 32'd0);
		add_sample(32'h1234_5678, 32'd120);
		add_sample(32'h0000_0042, 32'd140);
		query(16'd1, 16'd0);
		wait_idle();

		apb_write(ADDR_RETENTION, 32'd200);
		random_phase(130, 1'b0);
		wait_idle();
		send_idle_pct = 72;
		apb_write(ADDR_RETENTION, 32'd1);
		clock_now = $urandom;
		random_phase(130, 1'b1);
		wait_idle();
		send_idle_pct = 0;
		recv_stall_pct = 72;
		apb_write(ADDR_RETENTION, 32'd50 + $urandom_range(0, 5000));
		random_phase(130, 1'b0);
		wait_idle();
		send_idle_pct = 18;
		recv_stall_pct = 18;
		apb_write(ADDR_RETENTION, 32'd1048575);
		clock_now = 32'hFFFF_0000;
		random_phase(130, 1'b0);

		wait_idle();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
